// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the regression block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define RXLR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rxlr assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define RXLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rxlr assertion failed");

`endif

// ===== hw/rtl/rxlr_pkg.sv =====
// Types, constants and command/status structs of the rolling regression block.
package rxlr_pkg;

    localparam int MAX_WINDOW_DEF = 1024;
    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = 16;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int ICPT_W         = 48;
    localparam int SLOPE_W        = 33;
    localparam int R2_W           = 17;
    localparam int R2_FRAC        = 16;
    localparam int OP_W           = 64;
    localparam int WIDE_W         = 128;
    localparam int WIN_RESET      = 1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES   = 1'b1;

    typedef enum logic [1:0] {
        FIT_OK      = 2'd0,
        FIT_INVALID = 2'd1,
        FIT_FEW     = 2'd2,
        FIT_CONST_X = 2'd3
    } t_fit;

    typedef enum logic [2:0] {
        SQ_XO_XO, SQ_XO_YO, SQ_YO_YO, SQ_X_X, SQ_X_Y, SQ_Y_Y
    } t_sq_op;

    typedef enum logic [3:0] {
        MUL_N_SXX, MUL_SX_SX, MUL_N_SXY, MUL_SX_SY, MUL_N_SYY, MUL_SY_SY,
        MUL_SY_DXX, MUL_DXY_SX, MUL_N_DXX, MUL_DXY_DXY, MUL_DXX_DYY
    } t_mul_op;

    typedef enum logic [1:0] {
        DIV_SLOPE, DIV_ICPT, DIV_R2
    } t_div_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SUM, ST_CHK, ST_MUL, ST_MWAIT, ST_CHKX,
        ST_DIV, ST_DWAIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    sq_en;
        t_sq_op  sq_idx;
        logic    sum_en;
        logic    mul_start;
        t_mul_op mul_op;
        logic    div_start;
        t_div_op div_op;
        logic    res_clear;
        t_fit    res_status;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic has_invalid;
        logic too_few;
        logic dxx_nonpos;
        logic dyy_pos;
    } t_stat;

endpackage

// ===== hw/rtl/rxlr_mul.sv =====
// Sequential signed 64x64 multiplier, 16 bits of one operand per cycle.
module rxlr_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [rxlr_pkg::OP_W-1:0]     i_a,
    input  logic signed [rxlr_pkg::OP_W-1:0]     i_b,
    output logic                                 o_done,
    output logic signed [rxlr_pkg::WIDE_W-1:0]   o_p
);
    localparam int OW = rxlr_pkg::OP_W;
    localparam int WW = rxlr_pkg::WIDE_W;
    localparam int DG = 16;

    logic                r_busy, r_fin, r_done, r_neg;
    logic [1:0]          r_cnt;
    logic [OW-1:0]       r_ma, r_mb;
    logic [WW-1:0]       r_acc;
    logic signed [WW-1:0] r_p;
    logic [OW+DG-1:0]    w_pp;

    // one partial product from the top digit of the second operand
    assign w_pp = r_ma * r_mb[OW-1:OW-DG];

    // step through digits, then apply the sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ma   <= i_a[OW-1] ? OW'(0) - i_a : i_a;
                r_mb   <= i_b[OW-1] ? OW'(0) - i_b : i_b;
                r_neg  <= i_a[OW-1] ^ i_b[OW-1];
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= {r_acc[WW-DG-1:0], {DG{1'b0}}} + WW'(w_pp);
                r_mb  <= {r_mb[OW-DG-1:0], {DG{1'b0}}};
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_p    <= r_neg ? WW'(0) - r_acc : r_acc;
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

// ===== hw/rtl/rxlr_div.sv =====
// Restoring divider, one quotient bit per cycle, rounded to nearest.
module rxlr_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [rxlr_pkg::WIDE_W-1:0]   i_num,
    input  logic signed [rxlr_pkg::WIDE_W-1:0]   i_den,
    output logic                                 o_done,
    output logic signed [rxlr_pkg::WIDE_W-1:0]   o_q
);
    localparam int WW = rxlr_pkg::WIDE_W;
    localparam int CW = $clog2(WW);

    logic                 r_busy, r_fin, r_done, r_neg;
    logic [CW-1:0]        r_cnt;
    logic [WW-1:0]        r_n, r_d, r_r, r_q;
    logic signed [WW-1:0] r_res;
    logic [WW-1:0]        w_rem, w_abs_n, w_rnd;
    logic                 w_ge;

    assign w_abs_n = i_num[WW-1] ? WW'(0) - i_num : i_num;
    assign w_rem   = {r_r[WW-2:0], r_n[WW-1]};
    assign w_ge    = w_rem >= r_d;
    assign w_rnd   = (r_q + WW'(1)) >> 1;

    // shift in numerator bits, subtract where the divisor fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= w_abs_n << (rxlr_pkg::FRAC_BITS + 1);
                r_d    <= i_den[WW-1] ? WW'(0) - i_den : i_den;
                r_neg  <= i_num[WW-1] ^ i_den[WW-1];
                r_r    <= '0;
                r_q    <= '0;
                r_cnt  <= CW'(WW - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r   <= w_ge ? w_rem - r_d : w_rem;
                r_q   <= {r_q[WW-2:0], w_ge};
                r_n   <= {r_n[WW-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_res  <= r_neg ? WW'(0) - w_rnd : w_rnd;
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;
endmodule

// ===== hw/rtl/rxlr_dp.sv =====
// Datapath: sample ring, running sums, wide products, divisions and results.
module rxlr_dp #(
    parameter int MAX_WINDOW = rxlr_pkg::MAX_WINDOW_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [rxlr_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [rxlr_pkg::CFG_W-1:0]                 i_cfg_wdata,
    input  logic signed [rxlr_pkg::SAMPLE_BITS-1:0]    i_x,
    input  logic signed [rxlr_pkg::SAMPLE_BITS-1:0]    i_y,
    input  logic                                       i_ok,
    input  logic                                       i_last,
    input  rxlr_pkg::t_cmd                             i_cmd,
    output rxlr_pkg::t_stat                            o_stat,
    output logic [rxlr_pkg::ICPT_W-1:0]                o_icpt,
    output logic [rxlr_pkg::SLOPE_W-1:0]               o_slope,
    output logic [rxlr_pkg::R2_W-1:0]                  o_r2,
    output logic [1:0]                                 o_status,
    output logic                                       o_r2v
);
    localparam int SB = rxlr_pkg::SAMPLE_BITS;
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = SB + CW;
    localparam int QW = 2 * SB + CW - 1;
    localparam int PW = 2 * SB;
    localparam int OW = rxlr_pkg::OP_W;
    localparam int WW = rxlr_pkg::WIDE_W;
    localparam int IW = rxlr_pkg::ICPT_W;
    localparam int LW = rxlr_pkg::SLOPE_W;
    localparam int RW = rxlr_pkg::R2_W;

    // configuration and series state
    logic [rxlr_pkg::CFG_W-1:0] r_win_cfg, r_min;
    logic [AW-1:0]              r_wp;
    logic [CW-1:0]              r_fill, r_ic, w_win;
    logic signed [SW-1:0]       r_sx, r_sy;
    logic signed [QW-1:0]       r_sxx, r_sxy, r_syy;

    // per-item payload
    logic signed [SB-1:0] r_x, r_y;
    logic                 r_ok, r_last;
    logic [2*SB:0]        r_mem [MAX_WINDOW];
    logic [2*SB:0]        r_mq;
    logic signed [PW-1:0] r_prod [6];
    logic signed [WW-1:0] r_dxx, r_dxy, r_dyy, r_inum, r_iden, r_rnum, r_rden;
    logic [IW-1:0]        r_icpt, r_out_icpt;
    logic [LW-1:0]        r_slope, r_out_slope;
    logic [RW-1:0]        r_r2, r_out_r2;
    logic [1:0]           r_status, r_out_status;
    logic                 r_r2v, r_out_r2v;

    logic signed [SB-1:0] w_xo, w_yo, w_sa, w_sb;
    logic                 w_vo, w_rem, w_clear;
    logic signed [OW-1:0] w_ma, w_mb;
    logic signed [WW-1:0] w_dn, w_dd, w_mp, w_dq;
    logic                 w_mdone, w_ddone;
    logic signed [SW-1:0] w_ox, w_oy;
    logic signed [QW-1:0] w_oxx, w_oxy, w_oyy;

    // clamp the window register to the range 1 to the ring depth
    always_comb begin
        if (r_win_cfg == '0)
            w_win = CW'(1);
        else if (int'(r_win_cfg) > MAX_WINDOW)
            w_win = CW'(MAX_WINDOW);
        else
            w_win = CW'(r_win_cfg);
    end

    assign w_xo  = r_mq[SB-1:0];
    assign w_yo  = r_mq[2*SB-1:SB];
    assign w_vo  = r_mq[2*SB];
    assign w_rem = r_fill >= w_win;

    // oldest pair leaves only when the window is full
    assign w_ox  = w_rem ? SW'(w_xo) : '0;
    assign w_oy  = w_rem ? SW'(w_yo) : '0;
    assign w_oxx = w_rem ? QW'(r_prod[rxlr_pkg::SQ_XO_XO]) : '0;
    assign w_oxy = w_rem ? QW'(r_prod[rxlr_pkg::SQ_XO_YO]) : '0;
    assign w_oyy = w_rem ? QW'(r_prod[rxlr_pkg::SQ_YO_YO]) : '0;

    assign w_clear = (i_cmd.load_out && r_last) ||
                     (i_cfg_we && i_cfg_index == rxlr_pkg::REG_WINDOW_LENGTH);

    // configuration, counts and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cfg <= rxlr_pkg::CFG_W'(rxlr_pkg::WIN_RESET);
            r_min     <= '0;
            r_wp      <= '0;
            r_fill    <= '0;
            r_ic      <= '0;
            r_sx      <= '0;
            r_sy      <= '0;
            r_sxx     <= '0;
            r_sxy     <= '0;
            r_syy     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rxlr_pkg::REG_WINDOW_LENGTH)
                    r_win_cfg <= i_cfg_wdata;
                else
                    r_min <= i_cfg_wdata;
            end
            if (w_clear) begin
                r_wp   <= '0;
                r_fill <= '0;
                r_ic   <= '0;
                r_sx   <= '0;
                r_sy   <= '0;
                r_sxx  <= '0;
                r_sxy  <= '0;
                r_syy  <= '0;
            end else if (i_cmd.sum_en) begin
                r_sx  <= r_sx + SW'(r_x) - w_ox;
                r_sy  <= r_sy + SW'(r_y) - w_oy;
                r_sxx <= r_sxx + QW'(r_prod[rxlr_pkg::SQ_X_X]) - w_oxx;
                r_sxy <= r_sxy + QW'(r_prod[rxlr_pkg::SQ_X_Y]) - w_oxy;
                r_syy <= r_syy + QW'(r_prod[rxlr_pkg::SQ_Y_Y]) - w_oyy;
                r_fill <= w_rem ? w_win : r_fill + CW'(1);
                r_ic   <= r_ic + CW'(!r_ok)
                          - CW'(w_rem && !w_vo && r_ic != '0);
                r_wp   <= (CW'(r_wp) + CW'(1) == w_win) ? '0 : r_wp + AW'(1);
            end
        end
    end

    // sample ring: read the slot on accept, overwrite it at the sum update
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en)
            r_mem[r_wp] <= {r_ok, r_y, r_x};
        if (i_cmd.load_in)
            r_mq <= r_mem[r_wp];
    end

    // select the pair for the small products
    always_comb begin
        unique case (i_cmd.sq_idx)
            rxlr_pkg::SQ_XO_XO: begin w_sa = w_xo; w_sb = w_xo; end
            rxlr_pkg::SQ_XO_YO: begin w_sa = w_xo; w_sb = w_yo; end
            rxlr_pkg::SQ_YO_YO: begin w_sa = w_yo; w_sb = w_yo; end
            rxlr_pkg::SQ_X_X:   begin w_sa = r_x;  w_sb = r_x;  end
            rxlr_pkg::SQ_X_Y:   begin w_sa = r_x;  w_sb = r_y;  end
            rxlr_pkg::SQ_Y_Y:   begin w_sa = r_y;  w_sb = r_y;  end
            default:            begin w_sa = '0;   w_sb = '0;   end
        endcase
    end

    // select operands of the wide multiplier
    always_comb begin
        unique case (i_cmd.mul_op)
            rxlr_pkg::MUL_N_SXX:   begin w_ma = OW'(r_fill); w_mb = OW'(r_sxx); end
            rxlr_pkg::MUL_SX_SX:   begin w_ma = OW'(r_sx);   w_mb = OW'(r_sx);  end
            rxlr_pkg::MUL_N_SXY:   begin w_ma = OW'(r_fill); w_mb = OW'(r_sxy); end
            rxlr_pkg::MUL_SX_SY:   begin w_ma = OW'(r_sx);   w_mb = OW'(r_sy);  end
            rxlr_pkg::MUL_N_SYY:   begin w_ma = OW'(r_fill); w_mb = OW'(r_syy); end
            rxlr_pkg::MUL_SY_SY:   begin w_ma = OW'(r_sy);   w_mb = OW'(r_sy);  end
            rxlr_pkg::MUL_SY_DXX:  begin w_ma = OW'(r_sy);   w_mb = r_dxx[OW-1:0]; end
            rxlr_pkg::MUL_DXY_SX:  begin w_ma = r_dxy[OW-1:0]; w_mb = OW'(r_sx); end
            rxlr_pkg::MUL_N_DXX:   begin w_ma = OW'(r_fill); w_mb = r_dxx[OW-1:0]; end
            rxlr_pkg::MUL_DXY_DXY: begin w_ma = r_dxy[OW-1:0]; w_mb = r_dxy[OW-1:0]; end
            rxlr_pkg::MUL_DXX_DYY: begin w_ma = r_dxx[OW-1:0]; w_mb = r_dyy[OW-1:0]; end
            default:               begin w_ma = '0; w_mb = '0; end
        endcase
    end

    // select operands of the divider
    always_comb begin
        unique case (i_cmd.div_op)
            rxlr_pkg::DIV_SLOPE: begin w_dn = r_dxy;  w_dd = r_dxx;  end
            rxlr_pkg::DIV_ICPT:  begin w_dn = r_inum; w_dd = r_iden; end
            rxlr_pkg::DIV_R2:    begin w_dn = r_rnum; w_dd = r_rden; end
            default:             begin w_dn = '0;     w_dd = '0;     end
        endcase
    end

    rxlr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_p     (w_mp)
    );

    rxlr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_dn),
        .i_den   (w_dd),
        .o_done  (w_ddone),
        .o_q     (w_dq)
    );

    function automatic logic [IW-1:0] sat_icpt(input logic signed [WW-1:0] v);
        if (&v[WW-1:IW-1] || !(|v[WW-1:IW-1]))
            return v[IW-1:0];
        return v[WW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    endfunction

    function automatic logic [LW-1:0] sat_slope(input logic signed [WW-1:0] v);
        if (&v[WW-1:LW-1] || !(|v[WW-1:LW-1]))
            return v[LW-1:0];
        return v[WW-1] ? {1'b1, {(LW-1){1'b0}}} : {1'b0, {(LW-1){1'b1}}};
    endfunction

    function automatic logic [RW-1:0] clamp_r2(input logic signed [WW-1:0] v);
        if (v[WW-1])
            return '0;
        if (v > WW'(1 << rxlr_pkg::R2_FRAC))
            return RW'(1 << rxlr_pkg::R2_FRAC);
        return v[RW-1:0];
    endfunction

    // per-item payload: inputs, products, differences, results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x    <= i_ok ? i_x : '0;
            r_y    <= i_ok ? i_y : '0;
            r_ok   <= i_ok;
            r_last <= i_last;
        end
        if (i_cmd.sq_en)
            r_prod[i_cmd.sq_idx] <= w_sa * w_sb;
        // set or reduce the destination of the finished product
        if (w_mdone) begin
            unique case (i_cmd.mul_op)
                rxlr_pkg::MUL_N_SXX:   r_dxx  <= w_mp;
                rxlr_pkg::MUL_SX_SX:   r_dxx  <= r_dxx - w_mp;
                rxlr_pkg::MUL_N_SXY:   r_dxy  <= w_mp;
                rxlr_pkg::MUL_SX_SY:   r_dxy  <= r_dxy - w_mp;
                rxlr_pkg::MUL_N_SYY:   r_dyy  <= w_mp;
                rxlr_pkg::MUL_SY_SY:   r_dyy  <= r_dyy - w_mp;
                rxlr_pkg::MUL_SY_DXX:  r_inum <= w_mp;
                rxlr_pkg::MUL_DXY_SX:  r_inum <= r_inum - w_mp;
                rxlr_pkg::MUL_N_DXX:   r_iden <= w_mp;
                rxlr_pkg::MUL_DXY_DXY: r_rnum <= w_mp;
                rxlr_pkg::MUL_DXX_DYY: r_rden <= w_mp;
                default:               r_rden <= r_rden;
            endcase
        end
        if (i_cmd.res_clear) begin
            r_icpt   <= '0;
            r_slope  <= '0;
            r_r2     <= '0;
            r_r2v    <= 1'b0;
            r_status <= i_cmd.res_status;
        end else if (w_ddone) begin
            unique case (i_cmd.div_op)
                rxlr_pkg::DIV_SLOPE: r_slope <= sat_slope(w_dq);
                rxlr_pkg::DIV_ICPT:  r_icpt  <= sat_icpt(w_dq);
                rxlr_pkg::DIV_R2: begin
                    r_r2  <= clamp_r2(w_dq);
                    r_r2v <= 1'b1;
                end
                default: r_r2 <= r_r2;
            endcase
        end
        if (i_cmd.load_out) begin
            r_out_icpt   <= r_icpt;
            r_out_slope  <= r_slope;
            r_out_r2     <= r_r2;
            r_out_status <= r_status;
            r_out_r2v    <= r_r2v;
        end
    end

    assign o_stat.mul_done    = w_mdone;
    assign o_stat.div_done    = w_ddone;
    assign o_stat.has_invalid = r_ic != '0;
    assign o_stat.too_few     = (int'(r_fill) < int'(r_min)) || (r_fill < CW'(2));
    assign o_stat.dxx_nonpos  = r_dxx[WW-1] || (r_dxx == '0);
    assign o_stat.dyy_pos     = !r_dyy[WW-1] && (r_dyy != '0);

    assign o_icpt   = r_out_icpt;
    assign o_slope  = r_out_slope;
    assign o_r2     = r_out_r2;
    assign o_status = r_out_status;
    assign o_r2v    = r_out_r2v;
endmodule

// ===== hw/rtl/rxlr_ctrl.sv =====
// Controller: sequences one item through sums, products and divisions.
module rxlr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic            i_m_tready,
    output logic            o_m_tvalid,
    input  rxlr_pkg::t_stat i_stat,
    output rxlr_pkg::t_cmd  o_cmd
);
    rxlr_pkg::t_state  r_state, n_state;
    rxlr_pkg::t_sq_op  r_sq, n_sq;
    rxlr_pkg::t_mul_op r_k, n_k;
    rxlr_pkg::t_div_op r_d, n_d;
    logic              r_oval, n_oval;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rxlr_pkg::ST_IDLE;
            r_sq    <= rxlr_pkg::SQ_XO_XO;
            r_k     <= rxlr_pkg::MUL_N_SXX;
            r_d     <= rxlr_pkg::DIV_SLOPE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sq    <= n_sq;
            r_k     <= n_k;
            r_d     <= n_d;
            r_oval  <= n_oval;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_sq    = r_sq;
        n_k     = r_k;
        n_d     = r_d;
        o_cmd            = '0;
        o_cmd.sq_idx     = r_sq;
        o_cmd.mul_op     = r_k;
        o_cmd.div_op     = r_d;
        o_cmd.res_status = rxlr_pkg::FIT_OK;

        unique case (r_state)
            rxlr_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_sq    = rxlr_pkg::SQ_XO_XO;
                    n_state = rxlr_pkg::ST_SQ;
                end
            end
            rxlr_pkg::ST_SQ: begin
                o_cmd.sq_en = 1'b1;
                if (r_sq == rxlr_pkg::SQ_Y_Y)
                    n_state = rxlr_pkg::ST_SUM;
                else
                    n_sq = rxlr_pkg::t_sq_op'(r_sq + 3'd1);
            end
            rxlr_pkg::ST_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state = rxlr_pkg::ST_CHK;
            end
            rxlr_pkg::ST_CHK: begin
                o_cmd.res_clear = 1'b1;
                priority if (i_stat.has_invalid) begin
                    o_cmd.res_status = rxlr_pkg::FIT_INVALID;
                    n_state = rxlr_pkg::ST_OUT;
                end else if (i_stat.too_few) begin
                    o_cmd.res_status = rxlr_pkg::FIT_FEW;
                    n_state = rxlr_pkg::ST_OUT;
                end else begin
                    n_k     = rxlr_pkg::MUL_N_SXX;
                    n_state = rxlr_pkg::ST_MUL;
                end
            end
            rxlr_pkg::ST_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state = rxlr_pkg::ST_MWAIT;
            end
            rxlr_pkg::ST_MWAIT: begin
                if (i_stat.mul_done) begin
                    priority if (r_k == rxlr_pkg::MUL_SY_SY) begin
                        n_state = rxlr_pkg::ST_CHKX;
                    end else if (r_k == rxlr_pkg::MUL_DXX_DYY ||
                                 (r_k == rxlr_pkg::MUL_DXY_DXY && !i_stat.dyy_pos)) begin
                        n_d     = rxlr_pkg::DIV_SLOPE;
                        n_state = rxlr_pkg::ST_DIV;
                    end else begin
                        n_k     = rxlr_pkg::t_mul_op'(r_k + 4'd1);
                        n_state = rxlr_pkg::ST_MUL;
                    end
                end
            end
            rxlr_pkg::ST_CHKX: begin
                if (i_stat.dxx_nonpos) begin
                    o_cmd.res_clear  = 1'b1;
                    o_cmd.res_status = rxlr_pkg::FIT_CONST_X;
                    n_state = rxlr_pkg::ST_OUT;
                end else begin
                    n_k     = rxlr_pkg::MUL_SY_DXX;
                    n_state = rxlr_pkg::ST_MUL;
                end
            end
            rxlr_pkg::ST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = rxlr_pkg::ST_DWAIT;
            end
            rxlr_pkg::ST_DWAIT: begin
                if (i_stat.div_done) begin
                    if (r_d == rxlr_pkg::DIV_R2 ||
                        (r_d == rxlr_pkg::DIV_ICPT && !i_stat.dyy_pos)) begin
                        n_state = rxlr_pkg::ST_OUT;
                    end else begin
                        n_d     = rxlr_pkg::t_div_op'(r_d + 2'd1);
                        n_state = rxlr_pkg::ST_DIV;
                    end
                end
            end
            rxlr_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!r_oval || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = rxlr_pkg::ST_IDLE;
                end
            end
            default: n_state = rxlr_pkg::ST_IDLE;
        endcase

        if (o_cmd.load_out)
            n_oval = 1'b1;
        else if (i_m_tready)
            n_oval = 1'b0;
        else
            n_oval = r_oval;
    end

    assign o_s_tready = r_state == rxlr_pkg::ST_IDLE;
    assign o_m_tvalid = r_oval;
endmodule

// ===== hw/rtl/rolling_xy_linear_regression.sv =====
// Top level of the sliding-window least-squares line fit of y on x.
//
// Input stream: one (x, y) pair per item; tdata holds x then y, tuser holds
// the valid flag of the pair, tlast ends a series (window and sums clear
// after that item's result). Invalid pairs enter the window as zeros.
// Output stream: one result per item; tdata holds intercept (Q31.16),
// slope (Q16.16) and R squared (Q1.16); tuser holds status and the
// R squared valid flag.
// Throughput: one item at a time. A result with an invalid pair or too few
// samples skips the products and divisions, constant x stops after the
// products that form the spreads, and a full fit takes eleven 64x64 products
// on a 16-bit-per-cycle multiplier and three 128-bit restoring divisions;
// constant y drops one product and one division. The next item can be taken
// in the cycle after the result enters the output register.
// Stall: a result waits in the output register while tready is low; the
// next item is still accepted and computed, then held until the slot frees.
// Reset: synchronous, active low; clears window, counts and sums, sets
// window_length to 1024 and min_samples to 0. The ring needs no clearing.
// Config: write window_length (index 0, clears the series) or min_samples
// (index 1) only while no item is in flight.
`include "assert_macros.svh"

module rolling_xy_linear_regression #(
    parameter int MAX_WINDOW = rxlr_pkg::MAX_WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rxlr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rxlr_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [15:0] x_sample, [31:16] y_sample
    input  logic [31:0]                        i_s_tdata,
    // [0] sample_valid
    input  logic [0:0]                         i_s_tuser,
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [47:0] intercept, [80:48] slope, [97:81] r2, [103:98] zero
    output logic [103:0]                       o_m_tdata,
    // [1:0] fit_status, [2] r2_valid
    output logic [2:0]                         o_m_tuser
);
    localparam int SB = rxlr_pkg::SAMPLE_BITS;

    rxlr_pkg::t_cmd  w_cmd;
    rxlr_pkg::t_stat w_stat;
    logic [rxlr_pkg::ICPT_W-1:0]  w_icpt;
    logic [rxlr_pkg::SLOPE_W-1:0] w_slope;
    logic [rxlr_pkg::R2_W-1:0]    w_r2;
    logic [1:0]                   w_status;
    logic                         w_r2v;

    rxlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rxlr_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_x         (i_s_tdata[SB-1:0]),
        .i_y         (i_s_tdata[2*SB-1:SB]),
        .i_ok        (i_s_tuser[0]),
        .i_last      (i_s_tlast),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_icpt      (w_icpt),
        .o_slope     (w_slope),
        .o_r2        (w_r2),
        .o_status    (w_status),
        .o_r2v       (w_r2v)
    );

    // pack the result item
    assign o_m_tdata = {6'b0, w_r2, w_slope, w_icpt};
    assign o_m_tuser = {w_r2v, w_status};

    // an accepted item keeps the input closed on the next cycle
    `RXLR_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready)
    // R squared is flagged valid only on an ok fit
    `RXLR_ASSERT_SAME(a_r2v_needs_ok, o_m_tvalid && o_m_tuser[2],
                      o_m_tuser[1:0] == rxlr_pkg::FIT_OK)
    // a failed fit carries zero values
    `RXLR_ASSERT_SAME(a_fail_zero, o_m_tvalid && o_m_tuser[1:0] != rxlr_pkg::FIT_OK,
                      o_m_tdata == '0 && !o_m_tuser[2])
endmodule

// ===== test/rolling_xy_linear_regression_checker.sv =====
// Checker for the rolling regression block: predicts each fit and compares.
module rolling_xy_linear_regression_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rxlr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rxlr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [31:0]                    i_s_tdata,
    input  logic [0:0]                     i_s_tuser,
    input  logic                           i_s_tlast,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [103:0]                   i_m_tdata,
    input  logic [2:0]                     i_m_tuser,
    output int                             o_failures,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 1024;

    typedef struct {
        logic [rxlr_pkg::ICPT_W-1:0]  icpt;
        logic [rxlr_pkg::SLOPE_W-1:0] slope;
        logic [rxlr_pkg::R2_W-1:0]    r2;
        rxlr_pkg::t_fit               status;
        logic                         r2_ok;
    } t_fit_result;

    t_fit_result fit_queue[$];

    // Window model: ring of pairs, counts and exact sums
    longint xs_ring[RING];
    longint ys_ring[RING];
    bit     ok_ring[RING];
    int     wr_ptr, fill, bad_cnt;
    longint sx, sy, sxx, sxy, syy;
    int     win_len, min_pairs;

    assign o_pending = fit_queue.size();

    function automatic void clear_window();
        wr_ptr = 0; fill = 0; bad_cnt = 0;
        sx = 0; sy = 0; sxx = 0; sxy = 0; syy = 0;
    endfunction

    // round(num * 2^frac / den), ties away from zero
    function automatic logic signed [127:0] round_div(logic signed [127:0] num,
                                                      logic signed [127:0] den, int frac);
        logic [127:0] an, ad, q;
        logic         neg;
        neg = num[127] ^ den[127];
        an  = num[127] ? -num : num;
        ad  = den[127] ? -den : den;
        q   = ((an << (frac + 1)) / ad + 1) >> 1;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [127:0] clamp(logic signed [127:0] v, int w);
        logic signed [127:0] top;
        top = (128'sd1 <<< (w - 1)) - 1;
        if (v > top) return top;
        if (v < -top - 1) return -top - 1;
        return v;
    endfunction

    // Push one pair into the window and work out its fit
    function automatic t_fit_result fit_window(logic [31:0] data, logic ok, logic last);
        t_fit_result         res;
        longint              x, y, xo, yo;
        int                  win, p;
        logic signed [127:0] n, dxx, dxy, dyy, num, r, t;
        x   = ok ? longint'($signed(data[15:0])) : 0;
        y   = ok ? longint'($signed(data[31:16])) : 0;
        win = (win_len == 0) ? 1 : (win_len > RING ? RING : win_len);
        p   = wr_ptr % win;
        res.icpt   = '0;
        res.slope  = '0;
        res.r2     = '0;
        res.r2_ok  = 1'b0;
        res.status = rxlr_pkg::FIT_OK;
        if (fill >= win) begin
            xo = xs_ring[p]; yo = ys_ring[p];
            sx -= xo; sy -= yo; sxx -= xo * xo; sxy -= xo * yo; syy -= yo * yo;
            if (!ok_ring[p] && bad_cnt > 0) bad_cnt--;
            fill = win;
        end else begin
            fill++;
        end
        xs_ring[p] = x; ys_ring[p] = y; ok_ring[p] = ok;
        wr_ptr = (p + 1) % win;
        sx += x; sy += y; sxx += x * x; sxy += x * y; syy += y * y;
        if (!ok) bad_cnt++;
        n = 128'(fill);
        if (bad_cnt > 0) begin
            res.status = rxlr_pkg::FIT_INVALID;
        end else if (fill < min_pairs || fill < 2) begin
            res.status = rxlr_pkg::FIT_FEW;
        end else begin
            dxx = n * sxx - 128'(sx) * sx;
            dxy = n * sxy - 128'(sx) * sy;
            dyy = n * syy - 128'(sy) * sy;
            if (dxx <= 0) begin
                res.status = rxlr_pkg::FIT_CONST_X;
            end else begin
                num = 128'(sy) * dxx - dxy * sx;
                t = clamp(round_div(dxy, dxx, rxlr_pkg::FRAC_BITS), rxlr_pkg::SLOPE_W);
                res.slope = t[rxlr_pkg::SLOPE_W-1:0];
                t = clamp(round_div(num, n * dxx, rxlr_pkg::FRAC_BITS), rxlr_pkg::ICPT_W);
                res.icpt = t[rxlr_pkg::ICPT_W-1:0];
                if (dyy > 0) begin
                    r = round_div(dxy * dxy, dxx * dyy, rxlr_pkg::R2_FRAC);
                    if (r < 0)
                        t = '0;
                    else if (r > (128'sd1 <<< rxlr_pkg::R2_FRAC))
                        t = 128'sd1 <<< rxlr_pkg::R2_FRAC;
                    else
                        t = r;
                    res.r2    = t[rxlr_pkg::R2_W-1:0];
                    res.r2_ok = 1'b1;
                end
            end
        end
        if (last) clear_window();
        return res;
    endfunction

    // Track config, predict accepted items, compare accepted results
    always @(posedge i_clk) begin
        t_fit_result e;
        if (!i_rst_n) begin
            clear_window();
            win_len    = rxlr_pkg::WIN_RESET;
            min_pairs  = 0;
            o_failures = 0;
            fit_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rxlr_pkg::REG_WINDOW_LENGTH) begin
                    win_len = i_cfg_wdata;
                    clear_window();
                end else if (i_cfg_index == rxlr_pkg::REG_MIN_SAMPLES) begin
                    min_pairs = i_cfg_wdata;
                end
            end
            if (i_s_tvalid && i_s_tready)
                fit_queue.push_back(fit_window(i_s_tdata, i_s_tuser[0], i_s_tlast));
            if (i_m_tvalid && i_m_tready) begin
                if (fit_queue.size() == 0) begin
                    $error("result with no item outstanding");
                    o_failures++;
                end else begin
                    e = fit_queue.pop_front();
                    if (i_m_tdata[47:0] !== e.icpt) begin
                        $error("intercept: expected %0d, got %0d",
                               $signed(e.icpt), $signed(i_m_tdata[47:0]));
                        o_failures++;
                    end
                    if (i_m_tdata[80:48] !== e.slope) begin
                        $error("slope: expected %0d, got %0d",
                               $signed(e.slope), $signed(i_m_tdata[80:48]));
                        o_failures++;
                    end
                    if (i_m_tdata[97:81] !== e.r2) begin
                        $error("r2: expected %0d, got %0d", e.r2, i_m_tdata[97:81]);
                        o_failures++;
                    end
                    if (i_m_tuser[1:0] !== e.status) begin
                        $error("fit_status: expected %0d, got %0d", e.status, i_m_tuser[1:0]);
                        o_failures++;
                    end
                    if (i_m_tuser[2] !== e.r2_ok) begin
                        $error("r2_valid: expected %0d, got %0d", e.r2_ok, i_m_tuser[2]);
                        o_failures++;
                    end
                end
            end
        end
    end
endmodule

// ===== test/rolling_xy_linear_regression_test.sv =====
// Top of the rolling regression testbench: stimulus, stalls and verdict.
module rolling_xy_linear_regression_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 600;
    localparam int HOLD_CYCLES = 3000;

    logic                           i_clk = 0;
    logic                           i_rst_n = 0;
    logic                           cfg_we = 0;
    logic [rxlr_pkg::CFG_IDX_W-1:0] cfg_index = rxlr_pkg::REG_WINDOW_LENGTH;
    logic [rxlr_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_tvalid = 0, s_tready, s_tlast = 0;
    logic [31:0]                    s_tdata = '0;
    logic [0:0]                     s_tuser = '0;
    logic                           m_tvalid, m_tready = 0;
    logic [103:0]                   m_tdata;
    logic [2:0]                     m_tuser;
    int                             failures, pending;
    int                             idle_pct = 0, stall_pct = 0;
    bit                             hold_req = 0;
    bit                             hold_done = 0;
    int                             quiet = 0;

    always #2 i_clk = ~i_clk;

    rolling_xy_linear_regression dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser), .i_s_tlast(s_tlast),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    rolling_xy_linear_regression_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser), .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_failures(failures), .o_pending(pending)
    );

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_tready = 0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1;
            end
            m_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic offer_pair(logic [15:0] x, logic [15:0] y, logic ok, logic last);
        while ($urandom_range(0, 99) < idle_pct) @(negedge i_clk);
        s_tvalid = 1;
        s_tdata  = {y, x};
        s_tuser  = ok;
        s_tlast  = last;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        s_tvalid = 0;
    endtask

    // Wait for the block to drain, then write one register
    task automatic write_reg(logic [rxlr_pkg::CFG_IDX_W-1:0] idx,
                             logic [rxlr_pkg::CFG_W-1:0] val);
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we = 1; cfg_index = idx; cfg_wdata = val;
        @(negedge i_clk);
        cfg_we = 0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 3));
            2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            3: return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'd7;
        endcase
    endfunction

    typedef struct {
        int win, min_n, items, idle, stall;
        bit hold;
    } t_phase;

    t_phase phases[9] = '{
        '{8,    0,    150, 0,  0,  0},
        '{3,    2,    150, 85, 0,  0},
        '{16,   5,    150, 0,  85, 0},
        '{1,    0,    60,  24, 24, 0},
        '{0,    0,    40,  0,  0,  0},
        '{2047, 1024, 40,  24, 24, 0},
        '{1024, 0,    100, 0,  0,  1},
        '{5,    7,    100, 24, 24, 0},
        '{12,   3,    240, 0,  0,  0}
    };

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extremes, constant x, constant y, invalid pair, series end
        offer_pair(16'h8000, 16'h7fff, 1, 0);
        offer_pair(16'h7fff, 16'h8000, 1, 0);
        offer_pair(16'h0000, 16'h0000, 1, 0);
        offer_pair(16'd5, 16'd5, 1, 1);
        offer_pair(16'd3, 16'd1, 1, 0);
        offer_pair(16'd3, 16'd2, 1, 0);
        offer_pair(16'd3, -16'sd4, 1, 1);
        offer_pair(16'd1, 16'd4, 1, 0);
        offer_pair(16'd2, 16'd4, 1, 0);
        offer_pair(16'd3, 16'd4, 1, 1);
        offer_pair(16'd10, 16'd20, 0, 0);
        offer_pair(16'd1, 16'd1, 1, 0);
        offer_pair(16'd2, 16'd2, 1, 1);
        offer_pair(16'hffff, 16'hffff, 1, 0);
        offer_pair(16'h8000, 16'h8000, 1, 0);
        offer_pair(16'h7fff, 16'hffff, 1, 0);
        offer_pair(16'h8000, 16'h7fff, 1, 1);
        offer_pair(16'hffff, 16'h0000, 0, 1);

        // Random phases over a range of window and minimum settings, idle and stall patterns
        foreach (phases[i]) begin
            write_reg(rxlr_pkg::REG_WINDOW_LENGTH, phases[i].win[rxlr_pkg::CFG_W-1:0]);
            write_reg(rxlr_pkg::REG_MIN_SAMPLES, phases[i].min_n[rxlr_pkg::CFG_W-1:0]);
            idle_pct  = phases[i].idle;
            stall_pct = phases[i].stall;
            hold_req  = phases[i].hold;
            for (int k = 0; k < phases[i].items; k++)
                offer_pair(pick_sample(), pick_sample(),
                           $urandom_range(0, 99) < 93, $urandom_range(0, 99) < 4);
        end

        stall_pct = 0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== rolling_xy_linear_regression.f =====
+incdir+hw/rtl
hw/rtl/rxlr_pkg.sv
hw/rtl/rxlr_mul.sv
hw/rtl/rxlr_div.sv
hw/rtl/rxlr_dp.sv
hw/rtl/rxlr_ctrl.sv
hw/rtl/rolling_xy_linear_regression.sv
test/rolling_xy_linear_regression_checker.sv
test/rolling_xy_linear_regression_test.sv
